[hw/rtl/gbns_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gbns_pkg
// shared types and codes of the go-back-n sender: command record, action,
// frame and result codes
// ----------------------------------------------------------------------------
package gbns_pkg;

    // command passed from the front to the back
    typedef enum logic [1:0] {
        OP_WRITE,
        OP_SEND,
        OP_BAD
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] idx;   // store address or first frame number
        logic [3:0] cnt;   // data frames to send
        logic       fin;   // fin frame follows the data frames
        logic [7:0] data;  // byte to store
    } t_cmd;

    // input actions
    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_START   = 2'd1;
    localparam logic [1:0] ACT_RECV    = 2'd2;
    localparam logic [1:0] ACT_TIMEOUT = 2'd3;

    // received frame types
    localparam logic [1:0] FT_ACK = 2'd1;

    // result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_FIN  = 2'd1;
    localparam logic [1:0] KIND_BAD  = 2'd2;

    // window register
    localparam logic [3:0] WIN_RESET = 4'd3;
    localparam logic [3:0] WIN_MIN   = 4'd1;
    localparam logic [3:0] WIN_MAX   = 4'd8;

endpackage
`default_nettype wire

[hw/rtl/gbns_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gbns_if
// valid/ready channels of the go-back-n sender: input items and results
// ----------------------------------------------------------------------------
interface gbns_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] load_byte;
    logic [1:0] frame_type;
    logic [7:0] frame_number;

    modport source (
        output valid, action, load_byte, frame_type, frame_number,
        input  ready
    );
    modport sink (
        input  valid, action, load_byte, frame_type, frame_number,
        output ready
    );
endinterface

interface gbns_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [4:0] out_number;
    logic [7:0] out_data;
    logic       last;

    modport source (
        output valid, out_kind, out_number, out_data, last,
        input  ready
    );
    modport sink (
        input  valid, out_kind, out_number, out_data, last,
        output ready
    );
endinterface
`default_nettype wire

[hw/rtl/go_back_n_sender_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// go_back_n_sender_core
// go-back-n sender: loads a message, sends it in windows of data frames,
// slides on in-order acks, resends on timeout and closes with a fin frame
// ----------------------------------------------------------------------------
// usage
//   i_item   : input items (load byte, start, frame received, timeout), one
//              transfer per valid && ready
//   o_result : result frames (data, fin, bad-frame report); last marks the
//              final result caused by one input item; items that cause no
//              result produce no transfer
//   i_cfg_we / i_cfg_data : window size register, written while the block
//              is quiet; values 0 and above 8 act as 1 and 8
// operation
//   the front takes an item whenever the queue has room and queues at most
//   one command; the back takes a command while idle, then reads the store
//   and loads the output register for each data frame, and loads only the
//   output register for a fin or bad report; an item's first result passes
//   the queue, command capture, store read (data only) and output register
// reset
//   synchronous, active low: empty message, window base and next frame at
//   zero, loading phase, window size 3; store contents stay undefined
// stalls
//   a stalled receiver holds the output register; the back then stops and
//   the two-entry command queue fills before i_item.ready drops
// ----------------------------------------------------------------------------
module go_back_n_sender_core #(
    parameter int MAX_LEN = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gbns_item_if.sink     i_item,
    gbns_result_if.source o_result,
    input  logic          i_cfg_we,
    input  logic [3:0]    i_cfg_data
);
    import gbns_pkg::*;

    // front to queue
    t_cmd front_cmd;
    logic front_valid;
    logic q_full;
    logic q_ready;

    // queue to back
    t_cmd q_cmd;
    logic q_valid;
    logic back_ready;

    assign q_ready = !q_full;

    // classifies items and tracks window base, next frame and message length
    gbns_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (front_cmd),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (q_ready)
    );

    // decouples item acceptance from frame emission
    gbns_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_cmd),
        .i_pop   (back_ready)
    );

    // owns the message store and the output register
    gbns_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (back_ready),
        .o_result    (o_result)
    );

endmodule
`default_nettype wire

[hw/rtl/gbns_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gbns_front
// accepts input items, keeps the protocol state and turns each item into
// at most one command for the back
// ----------------------------------------------------------------------------
module gbns_front #(
    parameter int MAX_LEN = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gbns_item_if.sink     i_item,
    input  logic          i_cfg_we,
    input  logic [3:0]    i_cfg_data,
    output gbns_pkg::t_cmd o_cmd,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready
);
    import gbns_pkg::*;

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int WW = LW + 4;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SEND,
        PH_DONE
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [LW-1:0]   r_len, n_len;
    logic [LW-1:0]   r_base, n_base;
    logic [LW-1:0]   r_next, n_next;
    logic [3:0]      r_win;
    logic [3:0]      win_eff;
    logic            accept;
    logic [WW-1:0]   len_x, win_x, diff_x, start_cnt, tmo_cnt;
    logic [LW+7:0]   base_ext;
    logic [LW-1:0]   ack_next;
    logic            start_fin, ack_fin;

    assign i_item.ready = i_cmd_ready;
    assign accept       = i_item.valid && i_cmd_ready;

    // window clamped to 1..8
    assign win_eff = (r_win < WIN_MIN) ? WIN_MIN : ((r_win > WIN_MAX) ? WIN_MAX : r_win);

    assign len_x     = WW'(r_len);
    assign win_x     = WW'(win_eff);
    assign diff_x    = WW'(r_next - r_base);
    assign start_cnt = (len_x < win_x) ? len_x : win_x;
    assign tmo_cnt   = (diff_x < win_x) ? diff_x : win_x;
    assign start_fin = (len_x <= win_x);
    assign base_ext  = {8'd0, r_base};
    assign ack_next  = r_next + LW'(1);
    assign ack_fin   = (ack_next >= r_len);

    always_comb begin
        n_phase     = r_phase;
        n_len       = r_len;
        n_base      = r_base;
        n_next      = r_next;
        o_cmd       = '0;
        o_cmd_valid = 1'b0;
        if (accept) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_item.action == ACT_LOAD) begin
                        if (i_item.load_byte != 8'd0 && r_len < LW'(MAX_LEN)) begin
                            o_cmd.op    = OP_WRITE;
                            o_cmd.idx   = 8'(r_len);
                            o_cmd.data  = i_item.load_byte;
                            o_cmd_valid = 1'b1;
                            n_len       = r_len + LW'(1);
                        end
                    end else if (i_item.action == ACT_START) begin
                        o_cmd.op    = OP_SEND;
                        o_cmd.idx   = 8'd0;
                        o_cmd.cnt   = 4'(start_cnt);
                        o_cmd.fin   = start_fin;
                        o_cmd_valid = 1'b1;
                        n_base      = '0;
                        n_next      = LW'(start_cnt);
                        n_phase     = start_fin ? PH_DONE : PH_SEND;
                    end
                end
                PH_SEND: begin
                    if (i_item.action == ACT_RECV) begin
                        o_cmd_valid = 1'b1;
                        if (i_item.frame_type == FT_ACK &&
                            i_item.frame_number == base_ext[7:0]) begin
                            // window slides by one, next unsent frame goes out
                            o_cmd.op  = OP_SEND;
                            o_cmd.idx = 8'(r_next);
                            o_cmd.cnt = 4'd1;
                            o_cmd.fin = ack_fin;
                            n_next    = ack_next;
                            n_base    = r_base + LW'(1);
                            if (ack_fin) begin
                                n_phase = PH_DONE;
                            end
                        end else begin
                            o_cmd.op = OP_BAD;
                        end
                    end else if (i_item.action == ACT_TIMEOUT) begin
                        o_cmd.op    = OP_SEND;
                        o_cmd.idx   = 8'(r_base);
                        o_cmd.cnt   = 4'(tmo_cnt);
                        o_cmd_valid = (tmo_cnt != '0);
                    end
                end
                PH_DONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_len   <= '0;
            r_base  <= '0;
            r_next  <= '0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_base  <= n_base;
            r_next  <= n_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= WIN_RESET;
        end else if (i_cfg_we) begin
            r_win <= i_cfg_data;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/gbns_cmd_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gbns_cmd_fifo
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module gbns_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gbns_pkg::t_cmd i_data,
    output logic           o_full,
    output logic           o_valid,
    output gbns_pkg::t_cmd o_data,
    input  logic           i_pop
);
    import gbns_pkg::*;

    localparam int DEPTH = 2;

    t_cmd       r_mem [DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push, do_pop;

    assign o_full  = (r_count == 2'(DEPTH));
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

[hw/rtl/gbns_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gbns_back
// executes commands: stores message bytes, reads them back and emits
// data, fin and bad-frame results through an output register
// ----------------------------------------------------------------------------
module gbns_back #(
    parameter int MAX_LEN = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  gbns_pkg::t_cmd i_cmd,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    gbns_result_if.source  o_result
);
    import gbns_pkg::*;

    localparam int IW = $clog2(MAX_LEN);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EMIT,
        S_FIN,
        S_BAD
    } t_state;

    t_state     r_state;
    logic [7:0] r_idx;
    logic [3:0] r_cnt;
    logic       r_fin;
    logic       r_valid;
    logic [1:0] r_kind;
    logic [4:0] r_number;
    logic [7:0] r_data;
    logic       r_last;
    logic [7:0] r_rd_data;
    logic [7:0] mem [MAX_LEN];
    logic       mem_we;
    logic       out_free;
    logic       emit;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign out_free    = !r_valid || o_result.ready;
    assign mem_we      = (r_state == S_IDLE) && i_cmd_valid && (i_cmd.op == OP_WRITE);
    // output register loads a new result this cycle
    assign emit        = out_free &&
                         (r_state == S_EMIT || r_state == S_FIN || r_state == S_BAD);

    // message store, registered read at the current frame index
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[IW'(i_cmd.idx)] <= i_cmd.data;
        end
        r_rd_data <= mem[IW'(r_idx)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_valid <= 1'b1;
            end else if (r_valid && o_result.ready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        unique case (i_cmd.op)
                            OP_WRITE: begin
                            end
                            OP_SEND: begin
                                r_idx   <= i_cmd.idx;
                                r_cnt   <= i_cmd.cnt;
                                r_fin   <= i_cmd.fin;
                                r_state <= (i_cmd.cnt != 4'd0) ? S_READ : S_FIN;
                            end
                            OP_BAD: begin
                                r_state <= S_BAD;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_kind   <= KIND_DATA;
                        r_number <= r_idx[4:0];
                        r_data   <= r_rd_data;
                        r_last   <= (r_cnt == 4'd1) && !r_fin;
                        r_idx    <= r_idx + 8'd1;
                        r_cnt    <= r_cnt - 4'd1;
                        if (r_cnt == 4'd1) begin
                            r_state <= r_fin ? S_FIN : S_IDLE;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_kind   <= KIND_FIN;
                        r_number <= 5'd0;
                        r_data   <= 8'd0;
                        r_last   <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_BAD: begin
                    if (out_free) begin
                        r_kind   <= KIND_BAD;
                        r_number <= 5'd0;
                        r_data   <= 8'd0;
                        r_last   <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result.valid      = r_valid;
    assign o_result.out_kind   = r_kind;
    assign o_result.out_number = r_number;
    assign o_result.out_data   = r_data;
    assign o_result.last       = r_last;

endmodule
`default_nettype wire

[hw/rtl/gbns_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gbns_checker
// port-level checks on the result channel of the go-back-n sender
// ----------------------------------------------------------------------------
module gbns_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_out_kind,
    input logic [4:0] i_out_number,
    input logic [7:0] i_out_data,
    input logic       i_out_last
);
    import gbns_pkg::*;

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid &&
            $stable(i_out_kind) && $stable(i_out_number) &&
            $stable(i_out_data) && $stable(i_out_last))
        else $error("result changed while stalled");

    // only data, fin and bad reports are produced
    a_kind_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_kind == KIND_DATA || i_out_kind == KIND_FIN ||
            i_out_kind == KIND_BAD))
        else $error("unknown result kind");

    // fin and bad reports carry no number or byte
    a_ctrl_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind != KIND_DATA |->
            i_out_number == 5'd0 && i_out_data == 8'd0)
        else $error("fin or bad report with payload");

    // fin and bad reports always close their item
    a_ctrl_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind != KIND_DATA |-> i_out_last)
        else $error("fin or bad report not marked last");

endmodule

bind go_back_n_sender_core gbns_checker u_gbns_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_out_kind   (o_result.out_kind),
    .i_out_number (o_result.out_number),
    .i_out_data   (o_result.out_data),
    .i_out_last   (o_result.last)
);
`default_nettype wire
